// ----- hw/rtl/tstc_pkg.sv -----
// Shared types and constants for the touch swipe/tap classifier.
`timescale 1ns / 1ps
`default_nettype none

package tstc_pkg;

   localparam int CFG_PX_BITS  = 10;
   localparam int TAP_MS_BITS  = 16;
   localparam int TIME_BITS    = 32;
   localparam int GESTURE_BITS = 4;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CFG_PX_BITS-1:0] SWIPE_MIN_RESET   = 10'd57;
   localparam logic [CFG_PX_BITS-1:0] STILL_MAX_RESET   = 10'd31;
   localparam logic [TAP_MS_BITS-1:0] TAP_MAX_RESET     = 16'd700;
   localparam logic [CFG_PX_BITS-1:0] HOME_EDGE_RESET   = 10'd412;
   localparam logic [CFG_PX_BITS-1:0] READER_EDGE_RESET = 10'd460;

   typedef enum logic [GESTURE_BITS-1:0] {
      GESTURE_NONE  = 4'd0,
      GESTURE_BEGIN = 4'd1,
      GESTURE_HOME  = 4'd2,
      GESTURE_LEFT  = 4'd3,
      GESTURE_RIGHT = 4'd4,
      GESTURE_UP    = 4'd5,
      GESTURE_DOWN  = 4'd6,
      GESTURE_STOP  = 4'd7,
      GESTURE_TAP   = 4'd8
   } gesture_type;

   typedef enum logic [2:0] {
      REG_SWIPE_MIN   = 3'd0,
      REG_STILL_MAX   = 3'd1,
      REG_TAP_MAX     = 3'd2,
      REG_HOME_EDGE   = 3'd3,
      REG_READER_EDGE = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CFG_PX_BITS-1:0] swipe_travel_px;
      logic [CFG_PX_BITS-1:0] still_max_px;
      logic [TAP_MS_BITS-1:0] tap_limit_ms;
      logic [CFG_PX_BITS-1:0] home_edge_y;
      logic [CFG_PX_BITS-1:0] reader_home_edge_y;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tstc_if.sv -----
// Valid/ready channel interfaces for touch samples and gesture results.
`timescale 1ns / 1ps
`default_nettype none

interface tstc_req_if #(parameter int COORD_BITS = 10) ();
   logic                               valid;
   logic                               ready;
   logic                               pressed;
   logic [COORD_BITS-1:0]              pos_x;
   logic [COORD_BITS-1:0]              pos_y;
   logic [tstc_pkg::TIME_BITS-1:0]     time_ms;
   logic                               recording_now;
   logic                               overlay_active;
   logic                               reader_open;
   logic                               on_control;

   modport source (
      output valid, pressed, pos_x, pos_y, time_ms,
             recording_now, overlay_active, reader_open, on_control,
      input  ready
   );
   modport sink (
      input  valid, pressed, pos_x, pos_y, time_ms,
             recording_now, overlay_active, reader_open, on_control,
      output ready
   );
endinterface

interface tstc_rsp_if #(parameter int COORD_BITS = 10) ();
   logic                               valid;
   logic                               ready;
   logic [tstc_pkg::GESTURE_BITS-1:0]  gesture;
   logic [COORD_BITS-1:0]              tap_x;
   logic [COORD_BITS-1:0]              tap_y;
   logic [tstc_pkg::TIME_BITS-1:0]     tap_time_ms;

   modport source (output valid, gesture, tap_x, tap_y, tap_time_ms, input ready);
   modport sink (input valid, gesture, tap_x, tap_y, tap_time_ms, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/touch_swipe_tap_classifier_unit.sv -----
// Top level of the touch swipe/tap classifier: input stage, core and result register.
//
// Usage:
//   req_ch carries one polled touch sample per item (pressed, pos_x, pos_y,
//   time_ms and the mode flags); rsp_ch returns exactly one item per sample
//   with the gesture code and, for a tap, the press start point and time.
//   Thresholds are written through the APB port (psel/penable/pwrite/paddr/
//   pwdata); register i sits at byte address 4*i, pready is always high.
//   From sample accept to result valid the path is one input register,
//   then the classify compare logic feeding the result register.
//   Throughput is one item per cycle while rsp_ch.ready is high; the classification
//   is a few adds and compares on the stored press state, all inside that one stage.
//   Synchronous reset clears the press state, empties both stages and loads
//   the default thresholds. While rsp_ch.ready is low the result holds,
//   the input stage keeps one more item, and req_ch.ready drops once both
//   are occupied.
`timescale 1ns / 1ps
`default_nettype none

module touch_swipe_tap_classifier_unit #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   tstc_req_if.sink                                req_ch,
   tstc_rsp_if.source                              rsp_ch,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [tstc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [tstc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [tstc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                    pready
);

   tstc_pkg::cfg_type              cfg;

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_pressed_ff;
   logic [COORD_BITS-1:0]          s1_pos_x_ff, s1_pos_y_ff;
   logic [tstc_pkg::TIME_BITS-1:0] s1_time_ff;
   logic                           s1_rec_ff, s1_overlay_ff, s1_reader_ff, s1_control_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   tstc_pkg::gesture_type          rsp_gesture_ff, core_gesture;
   logic [COORD_BITS-1:0]          rsp_tap_x_ff, rsp_tap_y_ff, core_tap_x, core_tap_y;
   logic [tstc_pkg::TIME_BITS-1:0] rsp_tap_time_ff, core_tap_time;

   logic                           advance, req_fire, step;

   tstc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tstc_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .cfg            (cfg),
      .pressed        (s1_pressed_ff),
      .pos_x          (s1_pos_x_ff),
      .pos_y          (s1_pos_y_ff),
      .time_ms        (s1_time_ff),
      .recording_now  (s1_rec_ff),
      .overlay_active (s1_overlay_ff),
      .reader_open    (s1_reader_ff),
      .on_control     (s1_control_ff),
      .gesture        (core_gesture),
      .tap_x          (core_tap_x),
      .tap_y          (core_tap_y),
      .tap_time_ms    (core_tap_time)
   );

   // result register frees up when empty or taken this cycle
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign step         = s1_valid_ff && advance;

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.gesture     = rsp_gesture_ff;
   assign rsp_ch.tap_x       = rsp_tap_x_ff;
   assign rsp_ch.tap_y       = rsp_tap_y_ff;
   assign rsp_ch.tap_time_ms = rsp_tap_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pressed_ff <= req_ch.pressed;
         s1_pos_x_ff   <= req_ch.pos_x;
         s1_pos_y_ff   <= req_ch.pos_y;
         s1_time_ff    <= req_ch.time_ms;
         s1_rec_ff     <= req_ch.recording_now;
         s1_overlay_ff <= req_ch.overlay_active;
         s1_reader_ff  <= req_ch.reader_open;
         s1_control_ff <= req_ch.on_control;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_gesture_ff  <= core_gesture;
         rsp_tap_x_ff    <= core_tap_x;
         rsp_tap_y_ff    <= core_tap_y;
         rsp_tap_time_ff <= core_tap_time;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tstc_csr.sv -----
// APB configuration registers for the classifier thresholds.
`timescale 1ns / 1ps
`default_nettype none

module tstc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [tstc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [tstc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [tstc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                    pready,
   output tstc_pkg::cfg_type                       cfg
);

   tstc_pkg::cfg_type       cfg_ff;
   tstc_pkg::cfg_type       cfg_in;
   tstc_pkg::reg_index_type reg_index;
   logic                    wr_en;

   assign pready    = 1'b1;
   assign reg_index = tstc_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            tstc_pkg::REG_SWIPE_MIN:   cfg_in.swipe_travel_px    = pwdata[9:0];
            tstc_pkg::REG_STILL_MAX:   cfg_in.still_max_px       = pwdata[9:0];
            tstc_pkg::REG_TAP_MAX:     cfg_in.tap_limit_ms       = pwdata[15:0];
            tstc_pkg::REG_HOME_EDGE:   cfg_in.home_edge_y        = pwdata[9:0];
            tstc_pkg::REG_READER_EDGE: cfg_in.reader_home_edge_y = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         tstc_pkg::REG_SWIPE_MIN:   prdata = 32'(cfg_ff.swipe_travel_px);
         tstc_pkg::REG_STILL_MAX:   prdata = 32'(cfg_ff.still_max_px);
         tstc_pkg::REG_TAP_MAX:     prdata = 32'(cfg_ff.tap_limit_ms);
         tstc_pkg::REG_HOME_EDGE:   prdata = 32'(cfg_ff.home_edge_y);
         tstc_pkg::REG_READER_EDGE: prdata = 32'(cfg_ff.reader_home_edge_y);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_travel_px    <= tstc_pkg::SWIPE_MIN_RESET;
         cfg_ff.still_max_px       <= tstc_pkg::STILL_MAX_RESET;
         cfg_ff.tap_limit_ms       <= tstc_pkg::TAP_MAX_RESET;
         cfg_ff.home_edge_y        <= tstc_pkg::HOME_EDGE_RESET;
         cfg_ff.reader_home_edge_y <= tstc_pkg::READER_EDGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tstc_core.sv -----
// Press tracking and release classification for one sample per step cycle.
`timescale 1ns / 1ps
`default_nettype none

module tstc_core #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire tstc_pkg::cfg_type              cfg,
   input  wire logic                           pressed,
   input  wire logic [COORD_BITS-1:0]          pos_x,
   input  wire logic [COORD_BITS-1:0]          pos_y,
   input  wire logic [tstc_pkg::TIME_BITS-1:0] time_ms,
   input  wire logic                           recording_now,
   input  wire logic                           overlay_active,
   input  wire logic                           reader_open,
   input  wire logic                           on_control,
   output tstc_pkg::gesture_type               gesture,
   output logic      [COORD_BITS-1:0]          tap_x,
   output logic      [COORD_BITS-1:0]          tap_y,
   output logic      [tstc_pkg::TIME_BITS-1:0] tap_time_ms
);

   // common compare width for coordinates and 10-bit thresholds
   localparam int MW = (COORD_BITS > tstc_pkg::CFG_PX_BITS) ? COORD_BITS
                                                            : tstc_pkg::CFG_PX_BITS;

   logic                           was_pressed_ff, was_pressed_in;
   logic                           rec_at_press_ff, rec_at_press_in;
   logic [COORD_BITS-1:0]          start_x_ff, start_x_in;
   logic [COORD_BITS-1:0]          start_y_ff, start_y_in;
   logic [COORD_BITS-1:0]          latest_x_ff, latest_x_in;
   logic [COORD_BITS-1:0]          latest_y_ff, latest_y_in;
   logic [tstc_pkg::TIME_BITS-1:0] press_time_ff, press_time_in;

   logic [COORD_BITS:0]            dx, dy, mag_x, mag_y;
   logic                           dx_neg, dy_neg, dx_pos;
   logic [MW-1:0]                  ax, ay, smin, still, sy, edge_y;
   logic [tstc_pkg::TIME_BITS-1:0] elapsed;
   logic                           press_down, release_evt;
   logic                           is_home, is_horiz, is_vert, is_still;
   tstc_pkg::gesture_type          release_gesture;

   assign press_down  = pressed && !was_pressed_ff;
   assign release_evt = !pressed && was_pressed_ff;

   assign dx     = {1'b0, latest_x_ff} - {1'b0, start_x_ff};
   assign dy     = {1'b0, latest_y_ff} - {1'b0, start_y_ff};
   assign dx_neg = dx[COORD_BITS];
   assign dy_neg = dy[COORD_BITS];
   assign dx_pos = !dx_neg && (dx != '0);
   assign mag_x  = dx_neg ? (~dx + 1'b1) : dx;
   assign mag_y  = dy_neg ? (~dy + 1'b1) : dy;
   assign ax     = MW'(mag_x[COORD_BITS-1:0]);
   assign ay     = MW'(mag_y[COORD_BITS-1:0]);
   assign smin   = MW'(cfg.swipe_travel_px);
   assign still  = MW'(cfg.still_max_px);
   assign sy     = MW'(start_y_ff);
   assign edge_y = reader_open ? MW'(cfg.reader_home_edge_y) : MW'(cfg.home_edge_y);
   assign elapsed = time_ms - press_time_ff;

   assign is_home  = !overlay_active && (sy >= edge_y) && dy_neg && (ay > smin) && (ay > ax);
   assign is_horiz = !overlay_active && (ax > smin) && (ax > ay);
   assign is_vert  = !overlay_active && !reader_open && (ay > smin) && (ay > ax);
   assign is_still = (ax < still) && (ay < still)
                     && (elapsed < tstc_pkg::TIME_BITS'(cfg.tap_limit_ms));

   always_comb begin
      priority if (is_home) begin
         release_gesture = tstc_pkg::GESTURE_HOME;
      end else if (is_horiz) begin
         release_gesture = dx_pos ? tstc_pkg::GESTURE_RIGHT : tstc_pkg::GESTURE_LEFT;
      end else if (is_vert) begin
         release_gesture = dy_neg ? tstc_pkg::GESTURE_UP : tstc_pkg::GESTURE_DOWN;
      end else if (is_still && rec_at_press_ff) begin
         release_gesture = tstc_pkg::GESTURE_STOP;
      end else if (is_still && !reader_open && !on_control) begin
         release_gesture = tstc_pkg::GESTURE_TAP;
      end else begin
         release_gesture = tstc_pkg::GESTURE_NONE;
      end
   end

   always_comb begin
      if (press_down) begin
         gesture = tstc_pkg::GESTURE_BEGIN;
      end else if (release_evt) begin
         gesture = release_gesture;
      end else begin
         gesture = tstc_pkg::GESTURE_NONE;
      end
   end

   // start point and press time go out with a tap only
   always_comb begin
      if (gesture == tstc_pkg::GESTURE_TAP) begin
         tap_x       = start_x_ff;
         tap_y       = start_y_ff;
         tap_time_ms = press_time_ff;
      end else begin
         tap_x       = '0;
         tap_y       = '0;
         tap_time_ms = '0;
      end
   end

   always_comb begin
      was_pressed_in  = was_pressed_ff;
      rec_at_press_in = rec_at_press_ff;
      start_x_in      = start_x_ff;
      start_y_in      = start_y_ff;
      latest_x_in     = latest_x_ff;
      latest_y_in     = latest_y_ff;
      press_time_in   = press_time_ff;
      if (step) begin
         was_pressed_in = pressed;
         if (press_down) begin
            start_x_in      = pos_x;
            start_y_in      = pos_y;
            latest_x_in     = pos_x;
            latest_y_in     = pos_y;
            press_time_in   = time_ms;
            rec_at_press_in = recording_now;
         end else if (pressed) begin
            latest_x_in = pos_x;
            latest_y_in = pos_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff  <= 1'b0;
         rec_at_press_ff <= 1'b0;
      end else begin
         was_pressed_ff  <= was_pressed_in;
         rec_at_press_ff <= rec_at_press_in;
      end
   end

   // point and time are read only after a press has loaded them
   always_ff @(posedge clock) begin
      start_x_ff    <= start_x_in;
      start_y_ff    <= start_y_in;
      latest_x_ff   <= latest_x_in;
      latest_y_ff   <= latest_y_in;
      press_time_ff <= press_time_in;
   end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the touch swipe/tap classifier: random strokes against a predictor.
`timescale 1ns / 1ps

module tb;

   localparam int COORD_BITS   = 10;
   localparam int PX_MAX       = (1 << COORD_BITS) - 1;
   localparam int RUN_LIMIT    = 200000;
   localparam int ITEMS_PER_SET = 210;
   localparam int UNMAPPED_REG = 7;

   typedef struct packed {
      logic                           pressed;
      logic [COORD_BITS-1:0]          x;
      logic [COORD_BITS-1:0]          y;
      logic [tstc_pkg::TIME_BITS-1:0] t;
      logic                           rec;
      logic                           ovl;
      logic                           rdr;
      logic                           ctl;
   } sample_type;

   typedef struct packed {
      tstc_pkg::gesture_type          gesture;
      logic [COORD_BITS-1:0]          tap_x;
      logic [COORD_BITS-1:0]          tap_y;
      logic [tstc_pkg::TIME_BITS-1:0] tap_time;
   } report_type;

   typedef enum int {
      STROKE_TAP, STROKE_HORIZ, STROKE_VERT, STROKE_HOME, STROKE_WILD
   } stroke_type;

   logic                               clock;
   logic                               reset;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [tstc_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [tstc_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [tstc_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                               pready;

   tstc_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   tstc_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_ch ();

   touch_swipe_tap_classifier_unit #(.COORD_BITS(COORD_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // press tracker mirror and thresholds
   tstc_pkg::cfg_type              thresholds;
   logic                           was_down;
   logic [COORD_BITS-1:0]          origin_x, origin_y, last_x, last_y;
   logic [tstc_pkg::TIME_BITS-1:0] press_ms;
   logic                           rec_at_press;

   sample_type pending_samples[$];
   report_type expected_reports[$];

   int req_sent, req_taken, rsp_taken, rsp_seen;
   int req_gap, rsp_stall, req_burst, rsp_burst;
   int mismatches, cycle_count, samples_queued;
   logic [tstc_pkg::TIME_BITS-1:0] tick_ms;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic tstc_pkg::gesture_type release_gesture(logic ovl, logic rdr, logic ctl,
                                                    logic [tstc_pkg::TIME_BITS-1:0] now);
      int dx, dy, ax, ay, smin, still;
      logic [tstc_pkg::CFG_PX_BITS-1:0] edge_y;
      logic [tstc_pkg::TIME_BITS-1:0] elapsed;
      dx = int'(last_x) - int'(origin_x);
      dy = int'(last_y) - int'(origin_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      smin = int'(thresholds.swipe_travel_px);
      still = int'(thresholds.still_max_px);
      edge_y = rdr ? thresholds.reader_home_edge_y : thresholds.home_edge_y;
      elapsed = now - press_ms;
      if (!ovl && origin_y >= edge_y && dy < -smin && ay > ax)
         return tstc_pkg::GESTURE_HOME;
      if (!ovl && ax > smin && ax > ay)
         return dx > 0 ? tstc_pkg::GESTURE_RIGHT : tstc_pkg::GESTURE_LEFT;
      if (!ovl && !rdr && ay > smin && ay > ax)
         return dy < 0 ? tstc_pkg::GESTURE_UP : tstc_pkg::GESTURE_DOWN;
      if (ax < still && ay < still && elapsed < thresholds.tap_limit_ms) begin
         if (rec_at_press)
            return tstc_pkg::GESTURE_STOP;
         if (!rdr && !ctl)
            return tstc_pkg::GESTURE_TAP;
      end
      return tstc_pkg::GESTURE_NONE;
   endfunction

   function automatic report_type classify_sample(sample_type s);
      report_type r;
      r = '0;
      r.gesture = tstc_pkg::GESTURE_NONE;
      if (s.pressed && !was_down) begin
         origin_x = s.x;
         origin_y = s.y;
         last_x = s.x;
         last_y = s.y;
         press_ms = s.t;
         rec_at_press = s.rec;
         r.gesture = tstc_pkg::GESTURE_BEGIN;
      end else if (s.pressed) begin
         last_x = s.x;
         last_y = s.y;
      end else if (was_down) begin
         r.gesture = release_gesture(s.ovl, s.rdr, s.ctl, s.t);
      end
      was_down = s.pressed;
      if (r.gesture == tstc_pkg::GESTURE_TAP) begin
         r.tap_x = origin_x;
         r.tap_y = origin_y;
         r.tap_time = press_ms;
      end
      return r;
   endfunction

   // mostly short random waits, now and then a run of back-to-back items
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst = $urandom_range(16, 48);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int jitter(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic int clamp_px(int v);
      return v < 0 ? 0 : (v > PX_MAX ? PX_MAX : v);
   endfunction

   task automatic push_sample(logic p, int x, int y, logic [tstc_pkg::TIME_BITS-1:0] t,
                              logic rec, logic ovl, logic rdr, logic ctl);
      sample_type s;
      s.pressed = p;
      s.x = x[COORD_BITS-1:0];
      s.y = y[COORD_BITS-1:0];
      s.t = t;
      s.rec = rec;
      s.ovl = ovl;
      s.rdr = rdr;
      s.ctl = ctl;
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   // press, optional holds, release; the release point itself is ignored by the block
   task automatic push_stroke(int sx, int sy, int ex, int ey,
                              logic [tstc_pkg::TIME_BITS-1:0] t0,
                              logic [tstc_pkg::TIME_BITS-1:0] dur, int extra_holds,
                              logic hold_end, logic rec, logic ovl, logic rdr, logic ctl);
      push_sample(1'b1, sx, sy, t0, rec, coin(), coin(), coin());
      repeat (extra_holds)
         push_sample(1'b1, $urandom_range(0, PX_MAX), $urandom_range(0, PX_MAX),
                     t0 + $urandom_range(0, 20), coin(), coin(), coin(), coin());
      if (hold_end)
         push_sample(1'b1, ex, ey, t0 + $urandom_range(0, 20), coin(), coin(), coin(), coin());
      push_sample(1'b0, $urandom_range(0, PX_MAX), $urandom_range(0, PX_MAX), t0 + dur,
                  coin(), ovl, rdr, ctl);
   endtask

   task automatic queue_stroke();
      stroke_type kind;
      int sx, sy, ex, ey, travel, still, tap_lim, edge_y;
      logic [tstc_pkg::TIME_BITS-1:0] dur;
      logic rec, ovl, rdr, ctl;
      kind = stroke_type'($urandom_range(0, 4));
      still = int'(thresholds.still_max_px);
      tap_lim = int'(thresholds.tap_limit_ms);
      rec = $urandom_range(0, 3) == 0;
      ovl = $urandom_range(0, 4) == 0;
      rdr = $urandom_range(0, 3) == 0;
      ctl = $urandom_range(0, 4) == 0;
      sx = $urandom_range(0, PX_MAX);
      sy = $urandom_range(0, PX_MAX);
      // aim the travel just around the swipe threshold
      travel = int'(thresholds.swipe_travel_px) + int'($urandom_range(0, 60)) - 2;
      if (travel < 0)
         travel = 0;
      case (kind)
         STROKE_TAP: begin
            ex = sx + jitter(still + 1);
            ey = sy + jitter(still + 1);
         end
         STROKE_HORIZ: begin
            ex = coin() ? sx + travel : sx - travel;
            ey = sy + jitter(travel / 2 + 1);
         end
         STROKE_VERT: begin
            ey = coin() ? sy + travel : sy - travel;
            ex = sx + jitter(travel / 2 + 1);
         end
         STROKE_HOME: begin
            edge_y = rdr ? int'(thresholds.reader_home_edge_y) : int'(thresholds.home_edge_y);
            sy = clamp_px(edge_y + int'($urandom_range(0, 60)) - 2);
            ey = sy - travel;
            ex = sx + jitter(travel / 2 + 1);
         end
         default: begin
            ex = $urandom_range(0, PX_MAX);
            ey = $urandom_range(0, PX_MAX);
         end
      endcase
      ex = clamp_px(ex);
      ey = clamp_px(ey);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: dur = $urandom_range(0, tap_lim);
         5, 6, 7:       dur = tap_lim - 1 + int'($urandom_range(0, 2));
         8:             dur = tap_lim + int'($urandom_range(0, 5000));
         default:       dur = $urandom;
      endcase
      push_stroke(sx, sy, ex, ey, tick_ms, dur, $urandom_range(0, 2),
                  $urandom_range(0, 5) != 0, rec, ovl, rdr, ctl);
      tick_ms = tick_ms + dur + $urandom_range(1, 40);
      // stray samples: idle polls and broken presses
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3))
            push_sample(coin(), $urandom_range(0, PX_MAX), $urandom_range(0, PX_MAX),
                        $urandom, coin(), coin(), coin(), coin());
   endtask

   task automatic settle();
      while (pending_samples.size() != 0 || req_taken != req_sent ||
             expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random();
      int first;
      first = samples_queued;
      while (samples_queued - first < ITEMS_PER_SET)
         queue_stroke();
      settle();
   endtask

   task automatic set_reg(int idx, logic [tstc_pkg::CSR_DATA_BITS-1:0] value);
      logic [tstc_pkg::CSR_DATA_BITS-1:0] mask, word;
      mask = (idx == tstc_pkg::REG_TAP_MAX) ? 32'h0000_FFFF : 32'h0000_03FF;
      // junk in the unused upper bits must be dropped
      word = ($urandom & ~mask) | (value & mask);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= tstc_pkg::CSR_ADDR_BITS'(idx * 4);
      pwdata <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         tstc_pkg::REG_SWIPE_MIN:
            thresholds.swipe_travel_px = word[tstc_pkg::CFG_PX_BITS-1:0];
         tstc_pkg::REG_STILL_MAX:
            thresholds.still_max_px = word[tstc_pkg::CFG_PX_BITS-1:0];
         tstc_pkg::REG_TAP_MAX:
            thresholds.tap_limit_ms = word[tstc_pkg::TAP_MS_BITS-1:0];
         tstc_pkg::REG_HOME_EDGE:
            thresholds.home_edge_y = word[tstc_pkg::CFG_PX_BITS-1:0];
         tstc_pkg::REG_READER_EDGE:
            thresholds.reader_home_edge_y = word[tstc_pkg::CFG_PX_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic load_thresholds(logic [31:0] swipe, logic [31:0] still, logic [31:0] tap,
                                  logic [31:0] home, logic [31:0] reader);
      set_reg(tstc_pkg::REG_SWIPE_MIN, swipe);
      set_reg(tstc_pkg::REG_STILL_MAX, still);
      set_reg(tstc_pkg::REG_TAP_MAX, tap);
      set_reg(tstc_pkg::REG_HOME_EDGE, home);
      set_reg(tstc_pkg::REG_READER_EDGE, reader);
   endtask

   // sample driver
   always @(negedge clock) begin : drive_samples
      sample_type s;
      if (!reset && (!req_ch.valid || req_taken == req_sent)) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap--;
         end else if (pending_samples.size() > 0) begin
            s = pending_samples.pop_front();
            req_ch.pressed <= s.pressed;
            req_ch.pos_x <= s.x;
            req_ch.pos_y <= s.y;
            req_ch.time_ms <= s.t;
            req_ch.recording_now <= s.rec;
            req_ch.overlay_active <= s.ovl;
            req_ch.reader_open <= s.rdr;
            req_ch.on_control <= s.ctl;
            req_ch.valid <= 1'b1;
            req_sent++;
            req_gap = draw_wait(req_burst);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_seen != rsp_taken) begin
            rsp_seen = rsp_taken;
            rsp_stall = draw_wait(rsp_burst);
         end
         if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor: predict on each accepted sample, check each accepted result
   always @(posedge clock) begin : watch
      sample_type s;
      report_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            s.pressed = req_ch.pressed;
            s.x = req_ch.pos_x;
            s.y = req_ch.pos_y;
            s.t = req_ch.time_ms;
            s.rec = req_ch.recording_now;
            s.ovl = req_ch.overlay_active;
            s.rdr = req_ch.reader_open;
            s.ctl = req_ch.on_control;
            expected_reports.push_back(classify_sample(s));
            req_taken <= req_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken <= rsp_taken + 1;
            if (expected_reports.size() == 0) begin
               $error("unexpected result item: gesture %0d", rsp_ch.gesture);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_ch.gesture !== want.gesture) begin
                  $error("gesture: expected %0d, got %0d", want.gesture, rsp_ch.gesture);
                  mismatches++;
               end
               if (rsp_ch.tap_x !== want.tap_x) begin
                  $error("tap_x: expected %0d, got %0d", want.tap_x, rsp_ch.tap_x);
                  mismatches++;
               end
               if (rsp_ch.tap_y !== want.tap_y) begin
                  $error("tap_y: expected %0d, got %0d", want.tap_y, rsp_ch.tap_y);
                  mismatches++;
               end
               if (rsp_ch.tap_time_ms !== want.tap_time) begin
                  $error("tap_time_ms: expected %h, got %h", want.tap_time, rsp_ch.tap_time_ms);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pressed = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.time_ms = '0;
      req_ch.recording_now = 1'b0;
      req_ch.overlay_active = 1'b0;
      req_ch.reader_open = 1'b0;
      req_ch.on_control = 1'b0;
      rsp_ch.ready = 1'b0;
      thresholds.swipe_travel_px = tstc_pkg::SWIPE_MIN_RESET;
      thresholds.still_max_px = tstc_pkg::STILL_MAX_RESET;
      thresholds.tap_limit_ms = tstc_pkg::TAP_MAX_RESET;
      thresholds.home_edge_y = tstc_pkg::HOME_EDGE_RESET;
      thresholds.reader_home_edge_y = tstc_pkg::READER_EDGE_RESET;
      was_down = 1'b0;
      origin_x = '0;
      origin_y = '0;
      last_x = '0;
      last_y = '0;
      press_ms = '0;
      rec_at_press = 1'b0;
      tick_ms = $urandom;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // release with nothing pressed
      push_sample(1'b0, PX_MAX, PX_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      // tap at the origin, one ms under the limit
      push_stroke(0, 0, 0, 0, 32'h0000_1000, 699, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      // small drift while recording, tick wraps during the press
      push_stroke(PX_MAX, PX_MAX, 1000, 1000, 32'hFFFF_FF00, 32'h110, 0, 1'b1,
                  1'b1, 1'b0, 1'b0, 1'b0);
      // tick runs backward: elapsed is huge
      push_stroke(200, 200, 200, 200, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b0);
      push_stroke(500, 1000, 500, 800, 32'h2000, 300, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      push_stroke(100, 500, 300, 510, 32'h3000, 300, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      // horizontal swipes still count in reader mode
      push_stroke(300, 500, 100, 490, 32'h4000, 300, 0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      push_stroke(500, 300, 505, 100, 32'h5000, 300, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      // overlay drops the swipe
      push_stroke(500, 100, 500, 300, 32'h6000, 300, 0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      // still presses with the tap withheld
      push_stroke(600, 600, 600, 600, 32'h7000, 100, 0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      push_stroke(600, 600, 600, 600, 32'h8000, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      run_random();

      load_thresholds($urandom_range(20, 150), $urandom_range(8, 60),
                      $urandom_range(100, 3000), $urandom_range(0, PX_MAX),
                      $urandom_range(0, PX_MAX));
      set_reg(UNMAPPED_REG, $urandom);
      run_random();

      load_thresholds(0, 0, 0, 0, 0);
      run_random();

      load_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
      run_random();

      load_thresholds($urandom_range(0, 300), $urandom_range(0, PX_MAX),
                      $urandom_range(0, 65535), $urandom_range(0, PX_MAX),
                      $urandom_range(0, PX_MAX));
      run_random();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
